@@ rtl/core/rdcl_pkg.sv @@
package rdcl_pkg;

   // Fixed geometry of the lock.
   localparam int CODE_DIGITS = 3;
   localparam int DIGIT_W     = 8;
   localparam int DIAL_W      = 9;
   localparam int TICK_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Remainder unit: the dividend is at most 511, the remainder stays below 256.
   localparam int MOD_DIVIDEND_W = 9;
   localparam int MOD_REM_W      = 8;
   localparam int MOD_STEPS      = MOD_DIVIDEND_W;
   localparam int MOD_COUNT_W    = $clog2(MOD_STEPS);

   // Dial size limits.
   localparam logic [DIAL_W-1:0] DIAL_MIN = DIAL_W'(2);
   localparam logic [DIAL_W-1:0] DIAL_MAX = DIAL_W'(256);

   // Register reset values.
   localparam logic [DIAL_W-1:0] DIAL_POSITIONS_RESET = DIAL_W'(100);
   localparam logic [TICK_W-1:0] STOP_TICKS_RESET     = TICK_W'(1000);
   localparam logic [TICK_W-1:0] LOCKOUT_FIRST_RESET  = TICK_W'(1000);
   localparam logic [TICK_W-1:0] LOCKOUT_SECOND_RESET = TICK_W'(5000);
   localparam logic [TICK_W-1:0] LOCKOUT_THIRD_RESET  = TICK_W'(30000);

   localparam logic [DIGIT_W-1:0] FAILURES_MAX = '1;
   localparam logic [TICK_W-1:0]  REST_MAX     = '1;

   typedef enum logic [1:0] {
      CMD_MOVE     = 2'd0,
      CMD_TICK     = 2'd1,
      CMD_ABANDON  = 2'd2,
      CMD_SET_CODE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PH_DIGIT1  = 3'd0,
      PH_DIGIT2  = 3'd1,
      PH_DIGIT3  = 3'd2,
      PH_OPEN    = 3'd3,
      PH_SUCCESS = 3'd4,
      PH_FAILED  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      MODE_VERIFY  = 2'd0,
      MODE_NEW     = 2'd1,
      MODE_CONFIRM = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIAL_POSITIONS = 3'd0,
      CSR_STOP_TICKS     = 3'd1,
      CSR_LOCKOUT_FIRST  = 3'd2,
      CSR_LOCKOUT_SECOND = 3'd3,
      CSR_LOCKOUT_THIRD  = 3'd4
   } csr_index_type;

   typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic mod_start;
      logic mod_sel_pos;
      logic pos_commit;
      logic publish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic turn;
      logic mod_busy;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/core/rdcl_mod_unit.sv @@
module rdcl_mod_unit
   import rdcl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [MOD_DIVIDEND_W-1:0] dividend,
   input  logic [DIAL_W-1:0]         divisor,
   output logic                      busy,
   output logic [MOD_REM_W-1:0]      remainder
);

   logic                      busy_ff, busy_in;
   logic [MOD_COUNT_W-1:0]    count_ff, count_in;
   logic [MOD_DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [MOD_REM_W-1:0]      rem_ff, rem_in;
   logic [MOD_REM_W:0]        trial;

   // One restoring step per cycle, most significant dividend bit first.
   always_comb begin
      trial    = {rem_ff, shift_ff[MOD_DIVIDEND_W-1]};
      busy_in  = busy_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         count_in = count_ff + MOD_COUNT_W'(1);
         if ((MOD_REM_W + 1)'(trial) >= (MOD_REM_W + 1)'(divisor)) begin
            rem_in = MOD_REM_W'(trial - (MOD_REM_W + 1)'(divisor));
         end else begin
            rem_in = MOD_REM_W'(trial);
         end
         if (count_ff == MOD_COUNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/rdcl_datapath.sv @@
module rdcl_datapath
   import rdcl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic [1:0]                 req_cmd,
   input  logic signed [DIGIT_W-1:0]  req_delta,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_phase,
   output logic [1:0]                 rsp_mode,
   output logic [DIGIT_W-1:0]         rsp_position,
   output logic                       rsp_locked_out,
   output logic                       rsp_code_saved,
   output logic [DIGIT_W-1:0]         rsp_saved_first,
   output logic [DIGIT_W-1:0]         rsp_saved_second,
   output logic [DIGIT_W-1:0]         rsp_saved_third
);

   // Configuration registers.
   logic [DIAL_W-1:0] dial_positions_ff;
   logic [TICK_W-1:0] stop_ticks_ff, lockout_first_ff, lockout_second_ff, lockout_third_ff;

   // Latched request.
   cmd_type                     cmd_ff;
   logic signed [DIGIT_W-1:0]   delta_ff;

   // Lock state.
   logic [DIGIT_W-1:0] pos_ff, pos_in;
   phase_type          phase_ff, phase_in;
   mode_type           mode_ff, mode_in;
   logic               done_ff, done_in;
   logic               moved_ff, moved_in;
   logic [TICK_W-1:0]  rest_ff, rest_in;
   code_type           entered_ff, entered_in;
   code_type           pending_ff, pending_in;
   code_type           stored_ff, stored_in;
   logic [DIGIT_W-1:0] failures_ff, failures_in;
   logic [TICK_W-1:0]  lockout_ff, lockout_in;
   logic               saved_ff, saved_in;

   // Output register.
   logic               rsp_valid_ff;
   phase_type          rsp_phase_ff;
   mode_type           rsp_mode_ff;
   logic [DIGIT_W-1:0] rsp_position_ff;
   logic               rsp_locked_ff;
   logic               rsp_saved_ff;
   code_type           rsp_code_ff;

   // Helpers.
   logic                      locked;
   logic                      cw, ccw;
   logic [DIGIT_W-1:0]        magnitude;
   logic [DIAL_W-1:0]         dial_size;
   logic [MOD_DIVIDEND_W-1:0] wrap_sum;
   logic [MOD_DIVIDEND_W-1:0] mod_dividend;
   logic                      mod_busy;
   logic [MOD_REM_W-1:0]      mod_rem;
   logic [TICK_W-1:0]         rest_next;
   logic [DIGIT_W-1:0]        fail_next;

   assign locked    = (failures_ff != '0) && (lockout_ff != '0);
   assign cw        = (delta_ff != '0) && !delta_ff[DIGIT_W-1];
   assign ccw       = delta_ff[DIGIT_W-1];
   assign magnitude = ccw ? DIGIT_W'(-delta_ff) : DIGIT_W'(delta_ff);

   // Effective dial size, clamped to the legal range.
   always_comb begin
      priority if (dial_positions_ff < DIAL_MIN) begin
         dial_size = DIAL_MIN;
      end else if (dial_positions_ff > DIAL_MAX) begin
         dial_size = DIAL_MAX;
      end else begin
         dial_size = dial_positions_ff;
      end
   end

   // Second pass: old position plus or minus the reduced step count.
   assign wrap_sum = cw
      ? MOD_DIVIDEND_W'({1'b0, pos_ff}) + MOD_DIVIDEND_W'({1'b0, mod_rem})
      : MOD_DIVIDEND_W'({1'b0, pos_ff}) + MOD_DIVIDEND_W'(dial_size)
        - MOD_DIVIDEND_W'({1'b0, mod_rem});
   assign mod_dividend = cmd.mod_sel_pos ? wrap_sum : MOD_DIVIDEND_W'({1'b0, magnitude});

   rdcl_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dividend),
      .divisor   (dial_size),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   // Status toward the controller.
   always_comb begin
      status.mod_busy = mod_busy;
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.turn     = (cmd_ff == CMD_MOVE) && !locked
                        && (((phase_ff == PH_DIGIT2) && ccw)
                            || (((phase_ff == PH_DIGIT1) || (phase_ff == PH_DIGIT3)) && cw));
   end

   assign rest_next = (rest_ff == REST_MAX) ? rest_ff : rest_ff + TICK_W'(1);
   assign fail_next = (failures_ff == FAILURES_MAX) ? failures_ff
                                                    : failures_ff + DIGIT_W'(1);

   // Next lock state for one executed request.
   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      mode_in     = mode_ff;
      done_in     = done_ff;
      moved_in    = moved_ff;
      rest_in     = rest_ff;
      entered_in  = entered_ff;
      pending_in  = pending_ff;
      stored_in   = stored_ff;
      failures_in = failures_ff;
      lockout_in  = lockout_ff;
      saved_in    = saved_ff;
      if (cmd.exec) begin
         saved_in = 1'b0;
         unique case (cmd_ff)
            CMD_MOVE: begin
               if (status.turn) begin
                  rest_in  = '0;
                  done_in  = 1'b0;
                  moved_in = 1'b1;
               end else if (!locked && (phase_ff == PH_OPEN) && ccw) begin
                  // Final move: act on the entry by mode.
                  priority if (mode_ff == MODE_VERIFY) begin
                     if (entered_ff == stored_ff) begin
                        phase_in = PH_SUCCESS;
                     end else begin
                        phase_in    = PH_FAILED;
                        failures_in = fail_next;
                        priority if (fail_next == DIGIT_W'(1)) begin
                           lockout_in = lockout_first_ff;
                        end else if (fail_next == DIGIT_W'(2)) begin
                           lockout_in = lockout_second_ff;
                        end else begin
                           lockout_in = lockout_third_ff;
                        end
                     end
                  end else if (mode_ff == MODE_NEW) begin
                     pending_in = entered_ff;
                     pos_in     = '0;
                     phase_in   = PH_DIGIT1;
                     mode_in    = MODE_CONFIRM;
                     done_in    = 1'b0;
                     moved_in   = 1'b0;
                     rest_in    = '0;
                     entered_in = '0;
                  end else begin
                     if (entered_ff == pending_ff) begin
                        stored_in = pending_ff;
                        phase_in  = PH_SUCCESS;
                        saved_in  = 1'b1;
                     end else begin
                        phase_in = PH_FAILED;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (lockout_ff != '0) begin
                  lockout_in = lockout_ff - TICK_W'(1);
               end
               // Rest timing confirms the current digit.
               if ((phase_ff < PH_OPEN) && !done_ff && moved_ff) begin
                  rest_in = rest_next;
                  if (rest_next >= stop_ticks_ff) begin
                     entered_in[phase_ff[1:0]] = pos_ff;
                     done_in  = 1'b1;
                     moved_in = 1'b0;
                     phase_in = phase_type'(phase_ff + 3'd1);
                  end
               end
            end
            CMD_ABANDON: begin
               pos_in     = '0;
               phase_in   = PH_DIGIT1;
               mode_in    = MODE_VERIFY;
               done_in    = 1'b0;
               moved_in   = 1'b0;
               rest_in    = '0;
               entered_in = '0;
            end
            CMD_SET_CODE: begin
               pos_in     = '0;
               phase_in   = PH_DIGIT1;
               mode_in    = MODE_NEW;
               done_in    = 1'b0;
               moved_in   = 1'b0;
               rest_in    = '0;
               entered_in = '0;
               pending_in = '0;
            end
         endcase
      end
      if (cmd.pos_commit) begin
         pos_in = mod_rem;
      end
   end

   // Lock state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dial_positions_ff <= DIAL_POSITIONS_RESET;
         stop_ticks_ff     <= STOP_TICKS_RESET;
         lockout_first_ff  <= LOCKOUT_FIRST_RESET;
         lockout_second_ff <= LOCKOUT_SECOND_RESET;
         lockout_third_ff  <= LOCKOUT_THIRD_RESET;
         pos_ff            <= '0;
         phase_ff          <= PH_DIGIT1;
         mode_ff           <= MODE_VERIFY;
         done_ff           <= 1'b0;
         moved_ff          <= 1'b0;
         rest_ff           <= '0;
         entered_ff        <= '0;
         pending_ff        <= '0;
         stored_ff         <= '0;
         failures_ff       <= '0;
         lockout_ff        <= '0;
         saved_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DIAL_POSITIONS: dial_positions_ff <= csr_data[DIAL_W-1:0];
               CSR_STOP_TICKS:     stop_ticks_ff     <= csr_data[TICK_W-1:0];
               CSR_LOCKOUT_FIRST:  lockout_first_ff  <= csr_data[TICK_W-1:0];
               CSR_LOCKOUT_SECOND: lockout_second_ff <= csr_data[TICK_W-1:0];
               CSR_LOCKOUT_THIRD:  lockout_third_ff  <= csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         mode_ff     <= mode_in;
         done_ff     <= done_in;
         moved_ff    <= moved_in;
         rest_ff     <= rest_in;
         entered_ff  <= entered_in;
         pending_ff  <= pending_in;
         stored_ff   <= stored_in;
         failures_ff <= failures_in;
         lockout_ff  <= lockout_in;
         saved_ff    <= saved_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request latch and response payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= cmd_type'(req_cmd);
         delta_ff <= req_delta;
      end
      if (cmd.publish) begin
         rsp_phase_ff    <= phase_ff;
         rsp_mode_ff     <= mode_ff;
         rsp_position_ff <= pos_ff;
         rsp_locked_ff   <= locked;
         rsp_saved_ff    <= saved_ff;
         rsp_code_ff     <= stored_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase        = rsp_phase_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_locked_out   = rsp_locked_ff;
   assign rsp_code_saved   = rsp_saved_ff;
   assign rsp_saved_first  = rsp_code_ff[0];
   assign rsp_saved_second = rsp_code_ff[1];
   assign rsp_saved_third  = rsp_code_ff[2];

endmodule

@@ rtl/core/rdcl_ctrl.sv @@
module rdcl_ctrl
   import rdcl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD_STEPS,
      ST_MOD_POSITION,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;

   // Command decode and next state.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.turn) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD_STEPS;
            end else begin
               state_in = ST_PUBLISH;
            end
         end
         ST_MOD_STEPS: begin
            if (!status.mod_busy) begin
               cmd.mod_start   = 1'b1;
               cmd.mod_sel_pos = 1'b1;
               state_in        = ST_MOD_POSITION;
            end
         end
         ST_MOD_POSITION: begin
            if (!status.mod_busy) begin
               cmd.pos_commit = 1'b1;
               state_in       = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/rotary_dial_combination_lock_core.sv @@
// Ticks, abandon, set-code and moves that leave the dial alone pass from the idle state
// through execute to publish; a move that turns the dial also spends two passes in the
// bit-serial remainder unit, one reducing the step count and one wrapping the dial position.
// One request is in work at a time; the next request is taken once the last is published.
// A stalled response delays the next publish.
// Reset is synchronous and active high; it restores the default register values
// and the idle lock state.
module rotary_dial_combination_lock_core
   import rdcl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_cmd,
   input  logic signed [DIGIT_W-1:0] req_delta,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_phase,
   output logic [1:0]                rsp_mode,
   output logic [DIGIT_W-1:0]        rsp_position,
   output logic                      rsp_locked_out,
   output logic                      rsp_code_saved,
   output logic [DIGIT_W-1:0]        rsp_saved_first,
   output logic [DIGIT_W-1:0]        rsp_saved_second,
   output logic [DIGIT_W-1:0]        rsp_saved_third,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   rdcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   rdcl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_cmd          (req_cmd),
      .req_delta        (req_delta),
      .csr_write        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_phase        (rsp_phase),
      .rsp_mode         (rsp_mode),
      .rsp_position     (rsp_position),
      .rsp_locked_out   (rsp_locked_out),
      .rsp_code_saved   (rsp_code_saved),
      .rsp_saved_first  (rsp_saved_first),
      .rsp_saved_second (rsp_saved_second),
      .rsp_saved_third  (rsp_saved_third)
   );

endmodule

@@ rtl/core/rdcl_checker.sv @@
module rdcl_checker
   import rdcl_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [2:0]                rsp_phase,
   input logic [1:0]                rsp_mode,
   input logic [DIGIT_W-1:0]        rsp_position,
   input logic                      rsp_code_saved
);

   logic [1:0] outstanding_ff;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Requests accepted but not yet answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         outstanding_ff <= outstanding_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         outstanding_ff <= outstanding_ff - 2'd1;
      end
   end

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase) && $stable(rsp_position))
      else $error("response dropped or changed while stalled");

   // Every response answers an accepted request.
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without a pending request");

   // At most one request in work and one response waiting.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("too many requests in flight");

   // A saved code always reports success in confirm mode.
   a_saved_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_saved |-> rsp_phase == PH_SUCCESS && rsp_mode == MODE_CONFIRM)
      else $error("code saved without a confirmed success");

endmodule

bind rotary_dial_combination_lock_core rdcl_checker u_rdcl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_phase      (rsp_phase),
   .rsp_mode       (rsp_mode),
   .rsp_position   (rsp_position),
   .rsp_code_saved (rsp_code_saved)
);

@@ dv/tb.sv @@
module tb
   import rdcl_pkg::*;
();

   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SEGMENT_ITEMS  = 170;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   // Expected response of the lock after one request.
   typedef struct packed {
      logic [2:0]         phase;
      logic [1:0]         mode;
      logic [DIGIT_W-1:0] position;
      logic               locked_out;
      logic               code_saved;
      code_type           saved;
   } lock_status_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_cmd = CMD_TICK;
   logic signed [DIGIT_W-1:0] req_delta = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_phase;
   logic [1:0]                rsp_mode;
   logic [DIGIT_W-1:0]        rsp_position;
   logic                      rsp_locked_out;
   logic                      rsp_code_saved;
   logic [DIGIT_W-1:0]        rsp_saved_first;
   logic [DIGIT_W-1:0]        rsp_saved_second;
   logic [DIGIT_W-1:0]        rsp_saved_third;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   rotary_dial_combination_lock_core DUT (.*);

   // Shadow copy of the configuration registers.
   logic [DIAL_W-1:0] cfg_dial;
   logic [TICK_W-1:0] cfg_stop;
   logic [TICK_W-1:0] cfg_lock_first;
   logic [TICK_W-1:0] cfg_lock_second;
   logic [TICK_W-1:0] cfg_lock_third;

   // Shadow copy of the lock state.
   logic [DIGIT_W-1:0] cur_pos;
   phase_type          cur_phase;
   mode_type           cur_mode;
   logic               digit_latched;
   logic               moved_since;
   logic [TICK_W-1:0]  rest_ticks;
   code_type           entry_code;
   code_type           pending_entry;
   code_type           saved_code;
   logic [DIGIT_W-1:0] fail_count;
   logic [TICK_W-1:0]  lock_left;

   lock_status_type lock_status_q[$];
   int              err_count = 0;
   int              req_count = 0;
   int              stall_cycles = 0;
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Lock state prediction
   // ---------------------------------------------------------------------

   function automatic int dial_size();
      if (cfg_dial < DIAL_MIN) return 2;
      if (cfg_dial > DIAL_MAX) return 256;
      return int'(cfg_dial);
   endfunction

   function automatic bit locked_now();
      return fail_count != 0 && lock_left != 0;
   endfunction

   function automatic void clear_entry(input mode_type next_mode);
      cur_pos       = '0;
      cur_phase     = PH_DIGIT1;
      cur_mode      = next_mode;
      digit_latched = 1'b0;
      moved_since   = 1'b0;
      rest_ticks    = '0;
      entry_code    = '0;
   endfunction

   function automatic void reset_lock_model();
      cfg_dial        = DIAL_POSITIONS_RESET;
      cfg_stop        = STOP_TICKS_RESET;
      cfg_lock_first  = LOCKOUT_FIRST_RESET;
      cfg_lock_second = LOCKOUT_SECOND_RESET;
      cfg_lock_third  = LOCKOUT_THIRD_RESET;
      clear_entry(MODE_VERIFY);
      pending_entry = '0;
      saved_code    = '0;
      fail_count    = '0;
      lock_left     = '0;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_DIAL_POSITIONS: cfg_dial        = data[DIAL_W-1:0];
         CSR_STOP_TICKS:     cfg_stop        = data[TICK_W-1:0];
         CSR_LOCKOUT_FIRST:  cfg_lock_first  = data[TICK_W-1:0];
         CSR_LOCKOUT_SECOND: cfg_lock_second = data[TICK_W-1:0];
         CSR_LOCKOUT_THIRD:  cfg_lock_third  = data[TICK_W-1:0];
         default: ;
      endcase
   endfunction

   // The final counter-clockwise move acts by mode.
   function automatic void open_move(output bit saved);
      saved = 1'b0;
      case (cur_mode)
         MODE_VERIFY: begin
            if (entry_code == saved_code) begin
               cur_phase = PH_SUCCESS;
            end else begin
               cur_phase = PH_FAILED;
               if (fail_count != FAILURES_MAX) fail_count = fail_count + 1'b1;
               case (fail_count)
                  8'd1:    lock_left = cfg_lock_first;
                  8'd2:    lock_left = cfg_lock_second;
                  default: lock_left = cfg_lock_third;
               endcase
            end
         end
         MODE_NEW: begin
            pending_entry = entry_code;
            clear_entry(MODE_CONFIRM);
         end
         default: begin
            if (entry_code == pending_entry) begin
               saved_code = pending_entry;
               cur_phase  = PH_SUCCESS;
               saved      = 1'b1;
            end else begin
               cur_phase = PH_FAILED;
            end
         end
      endcase
   endfunction

   function automatic void turn_dial(input int d, output bit saved);
      int n;
      int k;
      saved = 1'b0;
      if (locked_now() || cur_phase >= PH_SUCCESS) return;
      if (cur_phase == PH_OPEN) begin
         if (d < 0) open_move(saved);
         return;
      end
      if (cur_phase == PH_DIGIT2) begin
         if (d >= 0) return;
      end else if (d <= 0) begin
         return;
      end
      n = dial_size();
      k = (d < 0 ? -d : d) % n;
      if (d > 0) cur_pos = DIGIT_W'((int'(cur_pos) + k) % n);
      else cur_pos = DIGIT_W'((int'(cur_pos) + n - k) % n);
      rest_ticks    = '0;
      digit_latched = 1'b0;
      moved_since   = 1'b1;
   endfunction

   function automatic void rest_tick();
      if (lock_left != 0) lock_left = lock_left - 1'b1;
      if (cur_phase >= PH_OPEN || digit_latched || !moved_since) return;
      if (rest_ticks != REST_MAX) rest_ticks = rest_ticks + 1'b1;
      if (rest_ticks >= cfg_stop) begin
         entry_code[int'(cur_phase)] = cur_pos;
         digit_latched = 1'b1;
         moved_since   = 1'b0;
         cur_phase     = phase_type'(cur_phase + 3'd1);
      end
   endfunction

   // Advances the shadow state by one request and queues the expected response.
   function automatic void predict_lock_status(input cmd_type cmd,
                                               input logic signed [DIGIT_W-1:0] delta);
      lock_status_type st;
      bit              saved;
      saved = 1'b0;
      case (cmd)
         CMD_MOVE:    turn_dial(int'(delta), saved);
         CMD_TICK:    rest_tick();
         CMD_ABANDON: clear_entry(MODE_VERIFY);
         default: begin
            clear_entry(MODE_NEW);
            pending_entry = '0;
         end
      endcase
      st.phase      = cur_phase;
      st.mode       = cur_mode;
      st.position   = cur_pos;
      st.locked_out = locked_now();
      st.code_saved = saved;
      st.saved      = saved_code;
      lock_status_q.push_back(st);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // The receiver stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_req(input cmd_type cmd, input logic signed [DIGIT_W-1:0] delta);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_delta = delta;
      do @(posedge clock); while (!req_ready);
      predict_lock_status(cmd, delta);
      req_count++;
   endtask

   task automatic send_noise();
      send_req(cmd_type'($urandom_range(3)), DIGIT_W'($urandom));
   endtask

   // Drops the request line and waits until every response is back.
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (lock_status_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      quiesce();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic code_type make_code(input int d1, input int d2, input int d3);
      code_type c;
      c[0] = DIGIT_W'(d1);
      c[1] = DIGIT_W'(d2);
      c[2] = DIGIT_W'(d3);
      return c;
   endfunction

   // Turns the dial onto a target, always by at least one step.
   task automatic turn_to(input int target, input bit clockwise);
      int n;
      int k;
      int step;
      n = dial_size();
      k = clockwise ? (target - int'(cur_pos) % n + n) % n
                    : (int'(cur_pos) % n - target + n) % n;
      if (k == 0) k = n;
      while (k > 0) begin
         step = clockwise ? ((k > 127) ? 127 : k) : ((k > 128) ? 128 : k);
         send_req(CMD_MOVE, clockwise ? DIGIT_W'(step) : DIGIT_W'(-step));
         k -= step;
      end
   endtask

   // Dials a full three-digit entry from the first phase and makes the final move.
   task automatic dial_in_code(input code_type code, input bit noisy);
      int n;
      n = dial_size();
      while (locked_now()) send_req(CMD_TICK, DIGIT_W'($urandom));
      for (int i = 0; i < CODE_DIGITS; i++) begin
         // Wrong-direction and zero moves must leave the entry alone.
         if (noisy && $urandom_range(3) == 0) begin
            if ($urandom_range(3) == 0) send_req(CMD_MOVE, '0);
            else if (i == 1) send_req(CMD_MOVE, DIGIT_W'($urandom_range(127, 1)));
            else send_req(CMD_MOVE, DIGIT_W'(-$urandom_range(128, 1)));
         end
         turn_to(int'(code[i]) % n, i != 1);
         while (cur_phase == phase_type'(i)) send_req(CMD_TICK, DIGIT_W'($urandom));
         if (noisy && $urandom_range(3) == 0) send_req(CMD_TICK, DIGIT_W'($urandom));
      end
      if (noisy && $urandom_range(3) == 0) send_req(CMD_MOVE, DIGIT_W'($urandom_range(127, 1)));
      send_req(CMD_MOVE, DIGIT_W'(-$urandom_range(128, 1)));
   endtask

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         err_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      lock_status_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lock_status_q.size() == 0) begin
            err_count++;
            $display("%0t: response with no request outstanding, got phase %0d position %0d",
                     $time, rsp_phase, rsp_position);
         end else begin
            exp = lock_status_q.pop_front();
            check_field("phase", exp.phase, rsp_phase);
            check_field("mode", exp.mode, rsp_mode);
            check_field("position", exp.position, rsp_position);
            check_field("locked_out", exp.locked_out, rsp_locked_out);
            check_field("code_saved", exp.code_saved, rsp_code_saved);
            check_field("saved_first", exp.saved[0], rsp_saved_first);
            check_field("saved_second", exp.saved[1], rsp_saved_second);
            check_field("saved_third", exp.saved[2], rsp_saved_third);
         end
      end
   end

   // Watchdog: any handshake counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, stall_cycles, lock_status_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // A few requests under the reset configuration.
   task automatic test_reset_defaults();
      send_req(CMD_TICK, '0);
      send_req(CMD_MOVE, 8'sd5);
      send_req(CMD_MOVE, -8'sd3);
      send_req(CMD_TICK, 8'sh7F);
      send_req(CMD_ABANDON, 8'sh80);
   endtask

   // Direction rules, the final move, a failed verify and its lockout.
   task automatic test_direction_rules();
      write_reg(CSR_DIAL_POSITIONS, 16'd10);
      write_reg(CSR_STOP_TICKS, 16'd1);
      write_reg(CSR_LOCKOUT_FIRST, 16'd2);
      write_reg(CSR_LOCKOUT_SECOND, 16'd3);
      write_reg(CSR_LOCKOUT_THIRD, 16'd4);
      send_req(CMD_MOVE, -8'sd5);
      send_req(CMD_MOVE, 8'sd0);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_MOVE, 8'sd127);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_MOVE, 8'sd3);
      send_req(CMD_MOVE, 8'sh80);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_MOVE, 8'sd1);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_MOVE, 8'sd5);
      send_req(CMD_MOVE, -8'sd1);
      send_req(CMD_MOVE, -8'sd1);
      // Set-code is honored while the lockout runs; moves are not.
      send_req(CMD_SET_CODE, 8'sd0);
      send_req(CMD_MOVE, 8'sd4);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_MOVE, 8'sd4);
      send_req(CMD_ABANDON, 8'sd0);
   endtask

   // New code entry, a confirm mismatch, a saved code and a good verify.
   task automatic test_code_change();
      write_reg(CSR_STOP_TICKS, 16'd0);
      send_req(CMD_SET_CODE, 8'sd0);
      dial_in_code(make_code(5, 6, 7), 1'b0);
      dial_in_code(make_code(5, 6, 8), 1'b0);
      send_req(CMD_SET_CODE, 8'sd0);
      dial_in_code(make_code(1, 2, 3), 1'b0);
      dial_in_code(make_code(1, 2, 3), 1'b0);
      send_req(CMD_MOVE, -8'sd1);
      send_req(CMD_ABANDON, 8'sd0);
      dial_in_code(make_code(1, 2, 3), 1'b0);
      send_req(CMD_ABANDON, 8'sd0);
   endtask

   // Dial size clamping, register masking, wrap after a size change, long rest.
   task automatic test_config_edges();
      write_reg(CSR_DIAL_POSITIONS, 16'd256);
      send_req(CMD_MOVE, 8'sd127);
      send_req(CMD_MOVE, 8'sd100);
      // The position now lies beyond the new dial size.
      write_reg(CSR_DIAL_POSITIONS, 16'hFE0A);
      send_req(CMD_MOVE, 8'sd1);
      write_reg(CSR_DIAL_POSITIONS, 16'hFE00);
      send_req(CMD_MOVE, 8'sd1);
      write_reg(CSR_DIAL_POSITIONS, 16'd1);
      send_req(CMD_MOVE, 8'sd3);
      write_reg(CSR_DIAL_POSITIONS, 16'd511);
      send_req(CMD_MOVE, 8'sd127);
      write_reg(CSR_DIAL_POSITIONS, 16'd2);
      send_req(CMD_MOVE, 8'sd3);
      write_reg(CSR_UNUSED, 16'hFFFF);
      write_reg(CSR_STOP_TICKS, 16'hFFFF);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_TICK, 8'sd0);
      send_req(CMD_ABANDON, 8'sd0);
   endtask

   task automatic pick_random_config();
      logic [CSR_DATA_W-1:0] dial;
      case ($urandom_range(9))
         0:       dial = 16'd2;
         1:       dial = 16'd256;
         2:       dial = CSR_DATA_W'($urandom_range(1));
         3:       dial = CSR_DATA_W'($urandom_range(511, 257));
         default: dial = CSR_DATA_W'($urandom_range(256, 2));
      endcase
      write_reg(CSR_DIAL_POSITIONS, dial);
      write_reg(CSR_STOP_TICKS, CSR_DATA_W'($urandom_range(4)));
      write_reg(CSR_LOCKOUT_FIRST, CSR_DATA_W'($urandom_range(12)));
      write_reg(CSR_LOCKOUT_SECOND, CSR_DATA_W'($urandom_range(12)));
      write_reg(CSR_LOCKOUT_THIRD, CSR_DATA_W'($urandom_range(12)));
   endtask

   // Mostly complete entries with random digits, mixed with noise.
   task automatic test_random_segment(input int idle_pct, input int stall_pct);
      int       stop_at;
      int       n;
      code_type target;
      pick_random_config();
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = req_count + SEGMENT_ITEMS;
      while (req_count < stop_at) begin
         if ($urandom_range(99) < 72) begin
            if (cur_phase != PH_DIGIT1 || $urandom_range(7) == 0)
               send_req(($urandom_range(3) == 0) ? CMD_SET_CODE : CMD_ABANDON,
                        DIGIT_W'($urandom));
            n = dial_size();
            for (int i = 0; i < CODE_DIGITS; i++) target[i] = DIGIT_W'($urandom_range(n - 1));
            if (cur_mode == MODE_VERIFY && $urandom_range(1) == 0) target = saved_code;
            if (cur_mode == MODE_CONFIRM && $urandom_range(2) != 0) target = pending_entry;
            dial_in_code(target, 1'b1);
         end else begin
            repeat ($urandom_range(4, 1)) send_noise();
         end
      end
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   // Repeated failed verifies with no lockout, then the lockout for later failures.
   task automatic test_repeated_failures();
      code_type target;
      write_reg(CSR_DIAL_POSITIONS, 16'd16);
      write_reg(CSR_STOP_TICKS, 16'd0);
      write_reg(CSR_LOCKOUT_FIRST, 16'd0);
      write_reg(CSR_LOCKOUT_SECOND, 16'd0);
      write_reg(CSR_LOCKOUT_THIRD, 16'd0);
      repeat (12) begin
         if (cur_phase != PH_DIGIT1 || cur_mode != MODE_VERIFY) send_req(CMD_ABANDON, '0);
         for (int i = 0; i < CODE_DIGITS; i++) target[i] = DIGIT_W'($urandom_range(15));
         // Differs from the stored code in the first digit, so the verify fails.
         target[0] = DIGIT_W'((int'(saved_code[0]) + 1) % 16);
         dial_in_code(target, 1'b0);
      end
      write_reg(CSR_LOCKOUT_FIRST, 16'hFFFF);
      write_reg(CSR_LOCKOUT_SECOND, 16'hFFFF);
      write_reg(CSR_LOCKOUT_THIRD, 16'd3);
      repeat (3) begin
         send_req(CMD_ABANDON, '0);
         target = saved_code;
         target[0] = DIGIT_W'((int'(saved_code[0]) + 1) % 16);
         dial_in_code(target, 1'b0);
      end
      write_reg(CSR_LOCKOUT_THIRD, 16'hFFFF);
      send_req(CMD_ABANDON, '0);
      dial_in_code(target, 1'b0);
      send_req(CMD_ABANDON, '0);
      send_req(CMD_MOVE, 8'sd3);
      send_req(CMD_TICK, '0);
      send_req(CMD_MOVE, 8'sd3);
   endtask

   initial begin
      reset_lock_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_direction_rules();
      test_code_change();
      test_config_edges();
      test_random_segment(0, 0);
      test_random_segment(88, 0);
      test_random_segment(0, 88);
      test_random_segment(13, 13);
      test_random_segment(0, 0);
      test_random_segment(88, 0);
      test_random_segment(0, 88);
      test_random_segment(13, 13);
      test_repeated_failures();

      quiesce();
      if (err_count == 0 && lock_status_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/rdcl_pkg.sv
rtl/core/rdcl_mod_unit.sv
rtl/core/rdcl_datapath.sv
rtl/core/rdcl_ctrl.sv
rtl/core/rotary_dial_combination_lock_core.sv
rtl/core/rdcl_checker.sv
dv/tb.sv
